[hw/rtl/tcg_pkg.sv]
`default_nettype none

package tcg_pkg;

  // Field and register widths
  localparam int unsigned OP_W       = 3;
  localparam int unsigned FREQ_W     = 16;
  localparam int unsigned DUR_W      = 32;
  localparam int unsigned TCLK_W     = 27;
  localparam int unsigned TPM_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Shared divider: 48-bit dividend (16 x 32 product), 32-bit divisor
  localparam int unsigned DVD_W = 48;
  localparam int unsigned DVS_W = 32;
  localparam int unsigned CNT_W = 6;

  localparam logic [TCLK_W-1:0] TCLK_RESET = TCLK_W'(2000000);
  localparam logic [TPM_W-1:0]  TPM_RESET  = TPM_W'(2000);

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_TONE   = 3'd1,
    OP_CHIRP  = 3'd2,
    OP_STOP   = 3'd3,
    OP_MUTE   = 3'd4,
    OP_UNMUTE = 3'd5
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIFFERENTIAL   = 2'd0,
    REG_TIMER_CLOCK_HZ = 2'd1,
    REG_TICKS_PER_MS   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_QSTART,
    S_QWAIT,
    S_CSTART,
    S_CWAIT
  } state_e;

  typedef struct packed {
    logic accept;
    logic cfg_write;
    logic mul_load;
    logic div_start_q;
    logic div_start_c;
    logic freq_apply;
    logic cv_apply;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_chirp;
    logic need_cv;
    logic div_done;
    logic freq_go;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/tcg_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module tcg_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [tcg_pkg::DVD_W-1:0] dividend_i,
  input  wire logic [tcg_pkg::DVS_W-1:0] divisor_i,
  output logic      [tcg_pkg::DVD_W-1:0] quotient_o,
  output logic                           done_o
);
  import tcg_pkg::*;

  logic [DVS_W-1:0] acc_q, acc_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] trial;
  logic             ge;

  assign shifted = {acc_q, quo_q[DVD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = ~trial[DVS_W+1];

  always_comb begin
    acc_d  = acc_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      acc_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
      cnt_d  = CNT_W'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        acc_d = ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], ge};
        cnt_d = cnt_q - CNT_W'(1);
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = busy_q && (cnt_q == '0);

endmodule

`default_nettype wire

[hw/rtl/tcg_datapath.sv]
`default_nettype none

module tcg_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire tcg_pkg::cmd_t                  cmd_i,
  output tcg_pkg::sts_t                       sts_o,
  input  wire logic [tcg_pkg::OP_W-1:0]       op_i,
  input  wire logic [tcg_pkg::FREQ_W-1:0]     start_freq_i,
  input  wire logic [tcg_pkg::FREQ_W-1:0]     end_freq_i,
  input  wire logic [tcg_pkg::DUR_W-1:0]      duration_ms_i,
  input  wire logic [tcg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [tcg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                                drive_a_o,
  output logic                                drive_b_o,
  output logic                                playing_o,
  output logic      [tcg_pkg::FREQ_W-1:0]     current_freq_o
);
  import tcg_pkg::*;

  // Configuration
  logic              diff_q, diff_d;
  logic [TCLK_W-1:0] tclk_q, tclk_d;
  logic [TPM_W-1:0]  tpm_q, tpm_d;

  // Playback state
  logic              tone_q, tone_d;
  logic              chirp_q, chirp_d;
  logic              muted_q, muted_d;
  logic              wave_q, wave_d;
  logic              run_q, run_d;
  logic              pin_a_q, pin_a_d;
  logic              pin_b_q, pin_b_d;
  logic [FREQ_W-1:0] freq_q, freq_d;
  logic [FREQ_W-1:0] sw_start_q, sw_start_d;
  logic [FREQ_W-1:0] sw_end_q, sw_end_d;
  logic [DUR_W-1:0]  len_q, len_d;
  logic [DUR_W-1:0]  elapsed_q, elapsed_d;
  logic [TPM_W-1:0]  pre_q, pre_d;
  logic [FREQ_W-1:0] limit_q, limit_d;
  logic [FREQ_W-1:0] count_q, count_d;

  // Arithmetic
  logic [DVD_W-1:0]  prod_q;
  logic [FREQ_W-1:0] mag;
  logic              down;
  logic [DVD_W-1:0]  dividend;
  logic [DVS_W-1:0]  divisor;
  logic [DVD_W-1:0]  quo;
  logic [DVD_W-1:0]  quo_m1;
  logic [FREQ_W-1:0] cv;
  logic [FREQ_W-1:0] f_interp;
  logic              div_done;

  // Per-item helpers
  logic              active;
  logic [TPM_W:0]    pre_inc;
  logic [TPM_W-1:0]  tpm_eff;
  logic              ms_edge;
  logic [DUR_W-1:0]  elap_inc;
  logic              play_end;
  logic              tone_ok;
  logic              chirp_ok;

  assign active   = tone_q | chirp_q;
  assign tpm_eff  = (tpm_q == '0) ? TPM_W'(1) : tpm_q;
  assign pre_inc  = {1'b0, pre_q} + (TPM_W+1)'(1);
  assign ms_edge  = pre_inc >= {1'b0, tpm_eff};
  assign elap_inc = elapsed_q + DUR_W'(1);
  assign play_end = elap_inc >= len_q;
  assign tone_ok  = (start_freq_i != '0) && (duration_ms_i != '0);
  assign chirp_ok = (duration_ms_i != '0) && ((start_freq_i != '0) || (end_freq_i != '0));

  // Sweep direction and magnitude
  assign down = sw_end_q < sw_start_q;
  assign mag  = down ? (sw_start_q - sw_end_q) : (sw_end_q - sw_start_q);

  // Divider operands: interpolation or compare value
  assign dividend = cmd_i.div_start_q ? prod_q : DVD_W'(tclk_q);
  assign divisor  = cmd_i.div_start_q ? len_q : DVS_W'({freq_q, 1'b0});

  tcg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start_q | cmd_i.div_start_c),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  assign quo_m1   = quo - DVD_W'(1);
  assign cv       = (quo == '0) ? '0 :
                    ((|quo_m1[DVD_W-1:FREQ_W]) ? '1 : quo_m1[FREQ_W-1:0]);
  assign f_interp = down ? (sw_start_q - quo[FREQ_W-1:0]) : (sw_start_q + quo[FREQ_W-1:0]);

  always_comb begin
    sts_o.div_done   = div_done;
    sts_o.freq_go    = (f_interp != '0) && !muted_q;
    sts_o.need_chirp = (op_i == OP_TICK) && active && ms_edge && !play_end && chirp_q;
    sts_o.need_cv    = ((op_i == OP_TONE) && tone_ok && !muted_q) ||
                       ((op_i == OP_CHIRP) && chirp_ok && (start_freq_i != '0) && !muted_q) ||
                       ((op_i == OP_UNMUTE) && active && (freq_q != '0));
  end

  always_comb begin
    diff_d     = diff_q;
    tclk_d     = tclk_q;
    tpm_d      = tpm_q;
    tone_d     = tone_q;
    chirp_d    = chirp_q;
    muted_d    = muted_q;
    wave_d     = wave_q;
    run_d      = run_q;
    pin_a_d    = pin_a_q;
    pin_b_d    = pin_b_q;
    freq_d     = freq_q;
    sw_start_d = sw_start_q;
    sw_end_d   = sw_end_q;
    len_d      = len_q;
    elapsed_d  = elapsed_q;
    pre_d      = pre_q;
    limit_d    = limit_q;
    count_d    = count_q;

    if (cmd_i.cfg_write) begin
      case (cfg_index_i)
        REG_DIFFERENTIAL: begin
          run_d   = 1'b0;
          count_d = '0;
          pin_a_d = 1'b0;
          pin_b_d = 1'b0;
          tone_d  = 1'b0;
          chirp_d = 1'b0;
          diff_d  = cfg_wdata_i[0];
        end
        REG_TIMER_CLOCK_HZ: tclk_d = cfg_wdata_i[TCLK_W-1:0];
        REG_TICKS_PER_MS:   tpm_d  = cfg_wdata_i[TPM_W-1:0];
        default: ;
      endcase
    end

    if (cmd_i.accept) begin
      case (op_i)
        OP_TICK: begin
          if (run_q) begin
            if (count_q >= limit_q) begin
              count_d = '0;
              if (muted_q) begin
                pin_a_d = 1'b0;
                pin_b_d = 1'b0;
              end else begin
                wave_d  = ~wave_q;
                pin_a_d = ~wave_q;
                if (diff_q) begin
                  pin_b_d = wave_q;
                end
              end
            end else begin
              count_d = count_q + FREQ_W'(1);
            end
          end
          if (active) begin
            if (!ms_edge) begin
              pre_d = pre_inc[TPM_W-1:0];
            end else begin
              pre_d     = '0;
              elapsed_d = elap_inc;
              if (play_end) begin
                run_d   = 1'b0;
                count_d = '0;
                pin_a_d = 1'b0;
                pin_b_d = 1'b0;
                tone_d  = 1'b0;
                chirp_d = 1'b0;
              end
            end
          end
        end
        OP_TONE: begin
          if (!tone_ok) begin
            run_d   = 1'b0;
            count_d = '0;
            pin_a_d = 1'b0;
            pin_b_d = 1'b0;
            tone_d  = 1'b0;
            chirp_d = 1'b0;
          end else begin
            freq_d    = start_freq_i;
            len_d     = duration_ms_i;
            elapsed_d = '0;
            pre_d     = '0;
            wave_d    = 1'b0;
            tone_d    = 1'b1;
            chirp_d   = 1'b0;
          end
        end
        OP_CHIRP: begin
          if (!chirp_ok) begin
            run_d   = 1'b0;
            count_d = '0;
            pin_a_d = 1'b0;
            pin_b_d = 1'b0;
            tone_d  = 1'b0;
            chirp_d = 1'b0;
          end else begin
            sw_start_d = start_freq_i;
            sw_end_d   = end_freq_i;
            freq_d     = start_freq_i;
            len_d      = duration_ms_i;
            elapsed_d  = '0;
            pre_d      = '0;
            wave_d     = 1'b0;
            chirp_d    = 1'b1;
            tone_d     = 1'b0;
            if (start_freq_i == '0) begin
              run_d   = 1'b0;
              count_d = '0;
              pin_a_d = 1'b0;
              pin_b_d = 1'b0;
            end
          end
        end
        OP_STOP: begin
          run_d   = 1'b0;
          count_d = '0;
          pin_a_d = 1'b0;
          pin_b_d = 1'b0;
          tone_d  = 1'b0;
          chirp_d = 1'b0;
        end
        OP_MUTE: begin
          muted_d = 1'b1;
          run_d   = 1'b0;
          count_d = '0;
          pin_a_d = 1'b0;
          pin_b_d = 1'b0;
        end
        OP_UNMUTE: muted_d = 1'b0;
        default: ;
      endcase
    end

    // New chirp frequency; silence at 0 Hz
    if (cmd_i.freq_apply) begin
      freq_d = f_interp;
      if (f_interp == '0) begin
        run_d   = 1'b0;
        count_d = '0;
        pin_a_d = 1'b0;
        pin_b_d = 1'b0;
      end
    end

    // Restart the half-period counter at the new compare value
    if (cmd_i.cv_apply) begin
      limit_d = cv;
      count_d = '0;
      run_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_q     <= 1'b0;
      tclk_q     <= TCLK_RESET;
      tpm_q      <= TPM_RESET;
      tone_q     <= 1'b0;
      chirp_q    <= 1'b0;
      muted_q    <= 1'b0;
      wave_q     <= 1'b0;
      run_q      <= 1'b0;
      pin_a_q    <= 1'b0;
      pin_b_q    <= 1'b0;
      freq_q     <= '0;
      sw_start_q <= '0;
      sw_end_q   <= '0;
      len_q      <= '0;
      elapsed_q  <= '0;
      pre_q      <= '0;
      limit_q    <= '0;
      count_q    <= '0;
    end else begin
      diff_q     <= diff_d;
      tclk_q     <= tclk_d;
      tpm_q      <= tpm_d;
      tone_q     <= tone_d;
      chirp_q    <= chirp_d;
      muted_q    <= muted_d;
      wave_q     <= wave_d;
      run_q      <= run_d;
      pin_a_q    <= pin_a_d;
      pin_b_q    <= pin_b_d;
      freq_q     <= freq_d;
      sw_start_q <= sw_start_d;
      sw_end_q   <= sw_end_d;
      len_q      <= len_d;
      elapsed_q  <= elapsed_d;
      pre_q      <= pre_d;
      limit_q    <= limit_d;
      count_q    <= count_d;
    end
  end

  // Product register and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      prod_q <= DVD_W'(mag) * DVD_W'(elapsed_q);
    end
    if (cmd_i.out_load) begin
      drive_a_o      <= pin_a_d;
      drive_b_o      <= pin_b_d;
      playing_o      <= tone_d | chirp_d;
      current_freq_o <= (tone_d | chirp_d) ? freq_d : '0;
    end
  end

  a_run_unmuted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> !muted_q)
    else $error("half-period counter running while muted");

  a_pin_b_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !diff_q |-> !pin_b_q)
    else $error("pin b driven in single-ended mode");

endmodule

`default_nettype wire

[hw/rtl/tcg_ctrl.sv]
`default_nettype none

module tcg_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire tcg_pkg::sts_t sts_i,
  output tcg_pkg::cmd_t      cmd_o
);
  import tcg_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   idle;
  logic   in_fire;

  assign idle        = state_q == S_IDLE;
  assign cfg_ready_o = idle;
  // Hold input while busy, while a result waits, or while a register write is offered
  assign in_stall_o  = !idle || (out_valid_q && out_stall_i) || cfg_valid_i;
  assign in_fire     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (sts_i.need_chirp) begin
            state_d = S_MUL;
          end else if (sts_i.need_cv) begin
            state_d = S_CSTART;
          end
        end
      end
      S_MUL:    state_d = S_QSTART;
      S_QSTART: state_d = S_QWAIT;
      S_QWAIT: begin
        if (sts_i.div_done) begin
          state_d = sts_i.freq_go ? S_CSTART : S_IDLE;
        end
      end
      S_CSTART: state_d = S_CWAIT;
      S_CWAIT: begin
        if (sts_i.div_done) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.cfg_write = cfg_valid_i && idle;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept   = in_fire;
        cmd_o.out_load = in_fire && !sts_i.need_chirp && !sts_i.need_cv;
      end
      S_MUL:    cmd_o.mul_load    = 1'b1;
      S_QSTART: cmd_o.div_start_q = 1'b1;
      S_QWAIT: begin
        cmd_o.freq_apply = sts_i.div_done;
        cmd_o.out_load   = sts_i.div_done && !sts_i.freq_go;
      end
      S_CSTART: cmd_o.div_start_c = 1'b1;
      S_CWAIT: begin
        cmd_o.cv_apply = sts_i.div_done;
        cmd_o.out_load = sts_i.div_done;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a stalled result");

  a_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_QWAIT || state_q == S_CWAIT))
    else $error("divider finished outside a wait state");

  a_cv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CWAIT && sts_i.div_done) |=> (out_valid_q && state_q == S_IDLE))
    else $error("compare value applied without a result");

endmodule

`default_nettype wire

[hw/rtl/tone_and_chirp_generator_top.sv]
`default_nettype none

// Channel  Direction  Handshake                   Payload
// in       sink       in_valid_i / in_stall_o     op, start_freq, end_freq, duration_ms
// out      source     out_valid_o / out_stall_i   drive_a, drive_b, playing, current_freq
// cfg      sink       cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_wdata_i
//
// Sequencing: a tick, stop, mute, or a play that leaves the counter stopped loads its result
// as it is accepted. A play or unmute that starts the counter waits for the 48-step divide
// for the compare value. A chirp tick on a millisecond boundary runs one multiply, the
// 48-step interpolation divide, then the compare divide; it skips the compare divide
// when the new frequency is 0 Hz or the block is muted.
// Reset: rst_ni clears the playback state and loads the register defaults; the result outputs are not reset.
// Stalls: a waiting result sits in the output register; the next transfer is taken in
// the cycle the result leaves.
module tone_and_chirp_generator_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Item channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [tcg_pkg::OP_W-1:0]       op_i,
  input  wire logic [tcg_pkg::FREQ_W-1:0]     start_freq_i,
  input  wire logic [tcg_pkg::FREQ_W-1:0]     end_freq_i,
  input  wire logic [tcg_pkg::DUR_W-1:0]      duration_ms_i,
  // Result channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                drive_a_o,
  output logic                                drive_b_o,
  output logic                                playing_o,
  output logic      [tcg_pkg::FREQ_W-1:0]     current_freq_o,
  // Register write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [tcg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [tcg_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import tcg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence each item: accept, optional multiply and divides, result load
  tcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold tone state, the half-period counter, the shared divider and the result register
  tcg_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (op_i),
    .start_freq_i   (start_freq_i),
    .end_freq_i     (end_freq_i),
    .duration_ms_i  (duration_ms_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .drive_a_o      (drive_a_o),
    .drive_b_o      (drive_b_o),
    .playing_o      (playing_o),
    .current_freq_o (current_freq_o)
  );

endmodule

`default_nettype wire
